FILE: rtl/v2a_pkg.sv
package v2a_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_SCL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_LEN  = 3'd4,
    MODE_NORM = 3'd5,
    MODE_RSV6 = 3'd6,
    MODE_RSV7 = 3'd7
  } mode_t;

endpackage

FILE: rtl/v2a_if.sv
interface v2a_in_if #(parameter int W = 32) (input logic clk);
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic signed [W-1:0] ax;
  logic signed [W-1:0] ay;
  logic signed [W-1:0] bx;
  logic signed [W-1:0] by;
  logic signed [W-1:0] scalar_k;
  modport source (output valid, mode, ax, ay, bx, by, scalar_k, input ready);
  modport sink   (input valid, mode, ax, ay, bx, by, scalar_k, output ready);
endinterface

interface v2a_out_if #(parameter int W = 32) (input logic clk);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] rx;
  logic signed [W-1:0] ry;
  logic [W-1:0]        magnitude;
  logic                div_zero;
  logic                overflow;
  modport source (output valid, rx, ry, magnitude, div_zero, overflow, input ready);
  modport sink   (input valid, rx, ry, magnitude, div_zero, overflow, output ready);
endinterface

FILE: rtl/v2a_sqrt_cell.sv
// One restoring square-root step: brings down one bit pair of the radicand.
module v2a_sqrt_cell #(
  parameter int RW = 66,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rad_i,
  input  logic [QW+1:0] rem_i,
  input  logic [QW-1:0] root_i,
  output logic [RW-1:0] rad_o,
  output logic [QW+1:0] rem_o,
  output logic [QW-1:0] root_o
);
  logic [QW+1:0] rem_sh;
  logic [QW+1:0] trial;
  logic [QW+1:0] rem_nxt;
  logic [QW-1:0] root_nxt;

  always_comb begin
    rem_sh = {rem_i[QW-1:0], rad_i[RW-1 -: 2]};
    trial  = {root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[QW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[RW-3:0], 2'b00};
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
    end
  end
endmodule

FILE: rtl/v2a_div_cell.sv
// One restoring division step for both components, which share a divisor.
module v2a_div_cell #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] nx_i,
  input  logic [NW-1:0] ny_i,
  input  logic [DW:0]   remx_i,
  input  logic [DW:0]   remy_i,
  input  logic [NW-1:0] qx_i,
  input  logic [NW-1:0] qy_i,
  input  logic [DW-1:0] d,
  output logic [NW-1:0] nx_o,
  output logic [NW-1:0] ny_o,
  output logic [DW:0]   remx_o,
  output logic [DW:0]   remy_o,
  output logic [NW-1:0] qx_o,
  output logic [NW-1:0] qy_o
);
  logic [DW+1:0] shx, shy, dd;

  always_comb begin
    shx = {remx_i, nx_i[NW-1]};
    shy = {remy_i, ny_i[NW-1]};
    dd  = {2'b00, d};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_o <= {nx_i[NW-2:0], 1'b0};
      ny_o <= {ny_i[NW-2:0], 1'b0};
      if (shx >= dd) begin
        remx_o <= (DW+1)'(shx - dd);
        qx_o   <= {qx_i[NW-2:0], 1'b1};
      end else begin
        remx_o <= (DW+1)'(shx);
        qx_o   <= {qx_i[NW-2:0], 1'b0};
      end
      if (shy >= dd) begin
        remy_o <= (DW+1)'(shy - dd);
        qy_o   <= {qy_i[NW-2:0], 1'b1};
      end else begin
        remy_o <= (DW+1)'(shy);
        qy_o   <= {qy_i[NW-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/vec2_arith_unit.sv
// 2D vector unit, signed fixed point (WORD_BITS word, FRAC_BITS fraction bits).
//
// Items enter on the in_ channel (valid/ready) carrying a mode, vector A,
// vector B and a scalar k, and leave on the out_ channel with one result
// item each: rx, ry, magnitude and the div_zero and overflow flags.
//
// Every mode travels down one pipeline: an operand stage, a chain of
// square-root cells (one bit pair of |A|^2 per cell), a divisor-select
// stage, a chain of division cells (one quotient bit per component per
// cell, with the divisor shared by both) and a result stage. Throughput
// is one item per cycle while the receiver does not stall, since every
// cell is its own stage.
//
// When the receiver stalls, the whole pipeline holds; in_ready follows
// out_ready or an empty output register, so no item is lost or repeated.
// Reset (rst_n, synchronous, active low) clears only the valid bits.
module vec2_arith_unit #(
  parameter int FRAC_BITS = v2a_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = v2a_pkg::WORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  v2a_in_if.sink    in_ch,
  v2a_out_if.source out_ch
);
  import v2a_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int SQ  = W + 1;        // root bits for a 2W+2 bit radicand
  localparam int RW  = 2 * SQ;
  localparam int NW  = W + FRAC_BITS;
  localparam int NS  = 2 * W + FRAC_BITS + 1; // width of the values fed to saturation
  localparam int LAT = SQ + NW + 2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic signed [W-1:0] k;
  } opnd_t;

  // Global stall: everything advances when the output can take an item.
  logic adv;
  logic [LAT-1:0] vld_r;
  logic out_vld_r;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
      out_vld_r <= vld_r[LAT-1];
    end
  end
  assign out_ch.valid = out_vld_r;

  // Operand stage, with the squares of A. Each square is one W x W product.
  opnd_t op0_r;
  logic [2*W-1:0] sqx_r, sqy_r;
  logic [W-1:0] mx_in, my_in;
  assign mx_in = in_ch.ax[W-1] ? W'(-in_ch.ax) : W'(in_ch.ax);
  assign my_in = in_ch.ay[W-1] ? W'(-in_ch.ay) : W'(in_ch.ay);

  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r <= '{in_ch.mode, in_ch.ax, in_ch.ay, in_ch.bx, in_ch.by, in_ch.scalar_k};
      sqx_r <= mx_in * mx_in;
      sqy_r <= my_in * my_in;
    end
  end

  // Square-root chain; operands ride alongside the cells.
  logic [RW-1:0] rad  [SQ+1];
  logic [SQ+1:0] rem  [SQ+1];
  logic [SQ-1:0] root [SQ+1];
  opnd_t opq [SQ+1];

  assign rad[0]  = RW'({1'b0, sqx_r} + {1'b0, sqy_r});
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign opq[0]  = op0_r;

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    v2a_sqrt_cell #(.RW(RW), .QW(SQ)) u_cell (
      .clk(clk), .en(adv),
      .rad_i(rad[i]), .rem_i(rem[i]), .root_i(root[i]),
      .rad_o(rad[i+1]), .rem_o(rem[i+1]), .root_o(root[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) opq[i+1] <= opq[i];
    end
  end

  // Divisor select and scale product.
  opnd_t op1_r;
  logic [W-1:0] mag1_r, dvs_r;
  logic [2*W-1:0] pmx_r, pmy_r;
  logic [W-1:0] amx, amy, kmag, mag_s;
  opnd_t oq;
  assign oq    = opq[SQ];
  assign mag_s = W'(root[SQ]);
  assign amx   = oq.ax[W-1] ? W'(-oq.ax) : W'(oq.ax);
  assign amy   = oq.ay[W-1] ? W'(-oq.ay) : W'(oq.ay);
  assign kmag  = oq.k[W-1] ? W'(-oq.k) : W'(oq.k);

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r  <= oq;
      mag1_r <= mag_s;
      dvs_r  <= (oq.mode == MODE_NORM) ? mag_s : kmag;
      pmx_r  <= amx * kmag;
      pmy_r  <= amy * kmag;
    end
  end

  // Division chain. Numerator is |a| << FRAC_BITS, NW quotient bits.
  localparam int NC = NW;
  logic [NW-1:0] nx [NC+1], ny [NC+1], qx [NC+1], qy [NC+1];
  logic [W:0]    rx_ [NC+1], ry_ [NC+1];
  opnd_t        opd [NC+1];
  logic [W-1:0] dv  [NC+1];
  logic [W-1:0] mg  [NC+1];
  logic [2*W-1:0] px [NC+1], py [NC+1];

  assign nx[0]  = {op1_r.ax[W-1] ? W'(-op1_r.ax) : W'(op1_r.ax), FRAC_BITS'(0)};
  assign ny[0]  = {op1_r.ay[W-1] ? W'(-op1_r.ay) : W'(op1_r.ay), FRAC_BITS'(0)};
  assign qx[0]  = '0;
  assign qy[0]  = '0;
  assign rx_[0] = '0;
  assign ry_[0] = '0;
  assign opd[0] = op1_r;
  assign dv[0]  = dvs_r;
  assign mg[0]  = mag1_r;
  assign px[0]  = pmx_r;
  assign py[0]  = pmy_r;

  for (genvar j = 0; j < NC; j++) begin : g_div
    v2a_div_cell #(.NW(NW), .DW(W)) u_cell (
      .clk(clk), .en(adv),
      .nx_i(nx[j]), .ny_i(ny[j]), .remx_i(rx_[j]), .remy_i(ry_[j]),
      .qx_i(qx[j]), .qy_i(qy[j]), .d(dv[j]),
      .nx_o(nx[j+1]), .ny_o(ny[j+1]), .remx_o(rx_[j+1]), .remy_o(ry_[j+1]),
      .qx_o(qx[j+1]), .qy_o(qy[j+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        opd[j+1] <= opd[j];
        dv[j+1]  <= dv[j];
        mg[j+1]  <= mg[j];
        px[j+1]  <= px[j];
        py[j+1]  <= py[j];
      end
    end
  end

  // Result stage: sign, saturation and mode selection.
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_fn(input logic neg, input logic [NS-1:0] m);
    logic [W-1:0] v;
    logic o;
    begin
      o = 1'b0;
      if (neg) begin
        if (m > NS'(HALF)) begin v = HALF; o = 1'b1; end
        else v = W'(-m);
      end else begin
        if (m > NS'(HALF - 1'b1)) begin v = HALF - 1'b1; o = 1'b1; end
        else v = W'(m);
      end
      sat_fn = {o, v};
    end
  endfunction

  opnd_t ol;
  logic [W:0] sx, sy;
  logic [W-1:0] r_x, r_y, r_mag;
  logic r_dz, r_ov;
  logic [NS-1:0] ex, ey;
  logic nx_s, ny_s;

  assign ol = opd[NC];

  always_comb begin
    r_x = ol.ax; r_y = ol.ay; r_mag = '0; r_dz = 1'b0; r_ov = 1'b0;
    ex = '0; ey = '0; nx_s = 1'b0; ny_s = 1'b0;
    sx = '0; sy = '0;
    case (ol.mode) inside
      MODE_ADD, MODE_SUB: begin
        if (ol.mode == MODE_ADD) begin
          ex = NS'($signed({ol.ax[W-1], ol.ax}) + $signed({ol.bx[W-1], ol.bx}));
          ey = NS'($signed({ol.ay[W-1], ol.ay}) + $signed({ol.by[W-1], ol.by}));
        end else begin
          ex = NS'($signed({ol.ax[W-1], ol.ax}) - $signed({ol.bx[W-1], ol.bx}));
          ey = NS'($signed({ol.ay[W-1], ol.ay}) - $signed({ol.by[W-1], ol.by}));
        end
        nx_s = ex[W];
        ny_s = ey[W];
        if (nx_s) ex = NS'(-{ex[W], ex[W:0]}) & NS'({(W+1){1'b1}});
        else ex = ex & NS'({(W+1){1'b1}});
        if (ny_s) ey = NS'(-{ey[W], ey[W:0]}) & NS'({(W+1){1'b1}});
        else ey = ey & NS'({(W+1){1'b1}});
        sx = sat_fn(nx_s, ex); sy = sat_fn(ny_s, ey);
        r_x = sx[W-1:0]; r_y = sy[W-1:0]; r_ov = sx[W] | sy[W];
      end
      MODE_SCL: begin
        ex = NS'(px[NC] >> FRAC_BITS);
        ey = NS'(py[NC] >> FRAC_BITS);
        nx_s = ol.ax[W-1] ^ ol.k[W-1];
        ny_s = ol.ay[W-1] ^ ol.k[W-1];
        sx = sat_fn(nx_s, ex); sy = sat_fn(ny_s, ey);
        r_x = sx[W-1:0]; r_y = sy[W-1:0]; r_ov = sx[W] | sy[W];
      end
      MODE_DIV, MODE_NORM: begin
        if (ol.mode == MODE_NORM) r_mag = mg[NC];
        if (dv[NC] == '0) begin
          r_dz = 1'b1;
        end else begin
          ex = NS'(qx[NC]);
          ey = NS'(qy[NC]);
          nx_s = ol.ax[W-1] ^ ((ol.mode == MODE_DIV) & ol.k[W-1]);
          ny_s = ol.ay[W-1] ^ ((ol.mode == MODE_DIV) & ol.k[W-1]);
          sx = sat_fn(nx_s, ex); sy = sat_fn(ny_s, ey);
          r_x = sx[W-1:0]; r_y = sy[W-1:0]; r_ov = sx[W] | sy[W];
        end
      end
      MODE_LEN: r_mag = mg[NC];
      default: ;
    endcase
  end

  // Output register.
  logic [W-1:0] orx_r, ory_r, omag_r;
  logic odz_r, oov_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      orx_r  <= r_x;
      ory_r  <= r_y;
      omag_r <= r_mag;
      odz_r  <= r_dz;
      oov_r  <= r_ov;
    end
  end
  assign out_ch.rx        = orx_r;
  assign out_ch.ry        = ory_r;
  assign out_ch.magnitude = omag_r;
  assign out_ch.div_zero  = odz_r;
  assign out_ch.overflow  = oov_r;
endmodule

FILE: bench/vec2_arith_unit_tb.sv
module vec2_arith_unit_tb;
  import v2a_pkg::*;

  // The block is a fixed 84-stage pipeline at the default sizes; this allowance covers it.
  localparam int PIPE_DEPTH = 110;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic signed [31:0] WMAX = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  // One result item as the block should produce it.
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [31:0]        magnitude;
    logic               div_zero;
    logic               overflow;
  } vec_result_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   mismatches;
  int   hold_off_cycles;
  bit   steady_flow;
  int   idle_pct;

  vec_result_t awaited_results[$];

  v2a_in_if  #(.W(32)) in_ch (clk);
  v2a_out_if #(.W(32)) out_ch(clk);

  vec2_arith_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Magnitude of a signed word, widened so that the most negative value fits.
  function automatic logic [63:0] abs_word(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // Clamp a sign and magnitude pair into a signed word, flagging any clamp.
  function automatic logic signed [31:0] clamp_word(input bit neg, input logic [63:0] m,
                                                    inout bit ovf);
    if (neg) begin
      if (m > 64'h80000000) begin
        ovf = 1'b1;
        return WMIN;
      end
      return -$signed(m[31:0]);
    end
    if (m > 64'h7fffffff) begin
      ovf = 1'b1;
      return WMAX;
    end
    return m[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [32:0] s, inout bit ovf);
    logic signed [63:0] w;
    w = s;
    return clamp_word(w < 0, (w < 0) ? -w : w, ovf);
  endfunction

  // Shifted quotient of a component by a divisor magnitude, truncated toward zero.
  function automatic logic signed [31:0] scaled_quot(input logic signed [31:0] a, input bit dneg,
                                                     input logic [63:0] dmag, inout bit ovf);
    logic [63:0] q;
    q = (abs_word(a) << 16) / dmag;
    return clamp_word((a < 0) != dneg, q, ovf);
  endfunction

  // Floored Euclidean length of A, one result bit per bit pair of the square sum.
  function automatic logic [31:0] floor_length(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic [63:0]  sq;
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    sq = abs_word(x) * abs_word(x) + abs_word(y) * abs_word(y);
    rem = 0;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((sq >> (2 * i)) & 64'd3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[31:0];
  endfunction

  function automatic vec_result_t vector_op_result(input mode_t mode,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] bx, input logic signed [31:0] by,
      input logic signed [31:0] k);
    vec_result_t r;
    bit ovf;
    ovf = 1'b0;
    r = '0;
    r.rx = ax;
    r.ry = ay;
    case (mode)
      MODE_ADD: begin
        r.rx = sat_sum(33'(ax) + 33'(bx), ovf);
        r.ry = sat_sum(33'(ay) + 33'(by), ovf);
      end
      MODE_SUB: begin
        r.rx = sat_sum(33'(ax) - 33'(bx), ovf);
        r.ry = sat_sum(33'(ay) - 33'(by), ovf);
      end
      MODE_SCL: begin
        r.rx = clamp_word((ax < 0) != (k < 0), (abs_word(ax) * abs_word(k)) >> 16, ovf);
        r.ry = clamp_word((ay < 0) != (k < 0), (abs_word(ay) * abs_word(k)) >> 16, ovf);
      end
      MODE_DIV: begin
        if (k == 0) begin
          r.div_zero = 1'b1;
        end else begin
          r.rx = scaled_quot(ax, k < 0, abs_word(k), ovf);
          r.ry = scaled_quot(ay, k < 0, abs_word(k), ovf);
        end
      end
      MODE_LEN: begin
        r.magnitude = floor_length(ax, ay);
      end
      MODE_NORM: begin
        r.magnitude = floor_length(ax, ay);
        if (r.magnitude == 0) begin
          r.div_zero = 1'b1;
        end else begin
          r.rx = scaled_quot(ax, 1'b0, {32'd0, r.magnitude}, ovf);
          r.ry = scaled_quot(ay, 1'b0, {32'd0, r.magnitude}, ovf);
        end
      end
      default: begin
      end
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  // Offer one item, idling first at random, and hold it until the block takes it.
  // The valid line is only lowered when an idle gap is actually taken.
  task automatic send_item(input mode_t mode,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] bx, input logic signed [31:0] by,
      input logic signed [31:0] k);
    while (!steady_flow && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.mode  <= 3'($urandom);
      in_ch.ax    <= $urandom;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.ax       <= ax;
    in_ch.ay       <= ay;
    in_ch.bx       <= bx;
    in_ch.by       <= by;
    in_ch.scalar_k <= k;
    do @(posedge clk); while (!in_ch.ready);
    awaited_results.push_back(vector_op_result(mode, ax, ay, bx, by, k));
  endtask

  // An operand drawn from a mix of extremes, small values and full-range words.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(9))
      0: return WMAX;
      1: return WMIN;
      2: return 0;
      3: return $signed($urandom_range(8)) - 4;
      4: return $signed($urandom_range(32'h00400000)) - 32'sh00200000;
      5: return $signed($urandom_range(32'h04000000)) - 32'sh02000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    mode_t mode;
    logic signed [31:0] k;
    // The reserved modes only pass A through, so they are sent rarely.
    if ($urandom_range(19) == 0) mode = mode_t'(3'($urandom_range(7, 6)));
    else mode = mode_t'(3'($urandom_range(5)));
    k = pick_operand();
    if (mode == MODE_DIV && $urandom_range(9) == 0) k = 0;
    send_item(mode, pick_operand(), pick_operand(), pick_operand(), pick_operand(), k);
  endtask

  // Extremes of every field, every mode and each special case.
  task automatic test_directed();
    send_item(MODE_ADD,  WMAX, WMIN, WMAX, WMIN, 0);
    send_item(MODE_ADD,  WMAX, WMIN, WMIN, WMAX, 0);
    send_item(MODE_SUB,  WMIN, WMAX, WMAX, WMIN, 0);
    send_item(MODE_SUB,  ONE, -ONE, ONE, ONE, 0);
    send_item(MODE_SCL,  WMAX, WMIN, 0, 0, WMAX);
    send_item(MODE_SCL,  WMIN, WMAX, 0, 0, WMIN);
    send_item(MODE_SCL,  -3, 3, 0, 0, -ONE);
    send_item(MODE_SCL,  ONE, WMIN, 0, 0, 0);
    send_item(MODE_DIV,  ONE, -ONE, 0, 0, 0);
    send_item(MODE_DIV,  WMIN, WMAX, 0, 0, -ONE);
    send_item(MODE_DIV,  WMAX, WMIN, 0, 0, 1);
    send_item(MODE_DIV,  -7, 7, 0, 0, WMIN);
    send_item(MODE_LEN,  WMIN, WMIN, 0, 0, 0);
    send_item(MODE_LEN,  0, 0, 0, 0, 0);
    send_item(MODE_LEN,  3 * ONE, 4 * ONE, 0, 0, 0);
    send_item(MODE_NORM, 0, 0, 0, 0, 0);
    send_item(MODE_NORM, 3 * ONE, -4 * ONE, 0, 0, 0);
    send_item(MODE_NORM, WMIN, 0, 0, 0, 0);
    send_item(MODE_NORM, 1, 0, 0, 0, 0);
    send_item(MODE_NORM, WMAX, WMAX, 0, 0, 0);
    send_item(MODE_RSV6, -ONE, ONE, WMAX, WMIN, WMAX);
    send_item(MODE_RSV7, WMAX, WMIN, -1, -1, -1);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_item();
  endtask

  // A burst with no idling on either side.
  task automatic test_steady_flow(input int count);
    steady_flow = 1'b1;
    test_random(count);
    steady_flow = 1'b0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and the input to stall.
  task automatic test_back_pressure();
    hold_off_cycles = 3 * PIPE_DEPTH;
    test_random(150);
  endtask

  // The sink stalls at random, except while a hold-off or a steady stretch is running.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready    <= 1'b0;
    end else begin
      out_ch.ready <= steady_flow || ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result rx=%h ry=%h", $time, out_ch.rx, out_ch.ry);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.rx !== want.rx) begin
          $display("%0t: rx expected %h actual %h", $time, want.rx, out_ch.rx);
          mismatches++;
        end
        if (out_ch.ry !== want.ry) begin
          $display("%0t: ry expected %h actual %h", $time, want.ry, out_ch.ry);
          mismatches++;
        end
        if (out_ch.magnitude !== want.magnitude) begin
          $display("%0t: magnitude expected %h actual %h", $time, want.magnitude,
                   out_ch.magnitude);
          mismatches++;
        end
        if (out_ch.div_zero !== want.div_zero) begin
          $display("%0t: div_zero expected %b actual %b", $time, want.div_zero,
                   out_ch.div_zero);
          mismatches++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                   out_ch.overflow);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cycle_count     = 0;
    mismatches      = 0;
    hold_off_cycles = 0;
    steady_flow     = 1'b0;
    idle_pct        = 13;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_ADD;
    in_ch.ax        = '0;
    in_ch.ay        = '0;
    in_ch.bx        = '0;
    in_ch.by        = '0;
    in_ch.scalar_k  = '0;
    out_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(500);
    test_back_pressure();
    test_steady_flow(200);
    test_random(280);

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
